>>> design/crcomb_pkg.sv
// Shared types, constants and helpers for the Chinese-remainder combiner.
package crcomb_pkg;

   // Fixed widths of the request and response fields.
   localparam int IN_BITS   = 16;
   localparam int PROD_BITS = 64;
   localparam int MUL_BITS  = 32;

   // Step counter of the shift-subtract divider holds up to PROD_BITS.
   localparam int DIV_CNT_BITS = $clog2(PROD_BITS + 1);

   // Defaults for the top-level parameters.
   localparam int DEF_MAX_PAIRS    = 4;
   localparam int DEF_MODULUS_BITS = 16;

   // Datapath operations issued by the controller.
   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_PROD,
      OP_DIV_LOAD,
      OP_DIV_STEP,
      OP_EUC_INIT,
      OP_EUC_MUL,
      OP_EUC_UPD,
      OP_INV,
      OP_RES_MUL,
      OP_TERM_MUL,
      OP_ROOM,
      OP_ACC,
      OP_OUT
   } dp_op_type;

   // Dividend source of a divider load; it also fixes divisor and step count.
   typedef enum logic [2:0] {
      DS_PROD,
      DS_COF,
      DS_R0,
      DS_RES,
      DS_MUL
   } div_src_type;

   // Controller states.
   typedef enum logic [4:0] {
      S_IDLE,
      S_PROD,
      S_COF_LD,
      S_COF_DIV,
      S_X_LD,
      S_X_DIV,
      S_EUC_INIT,
      S_EUC_TEST,
      S_EUC_DIV,
      S_EUC_MUL,
      S_EUC_UPD,
      S_INV,
      S_RES_LD,
      S_RES_DIV,
      S_RES_MUL,
      S_TERM_LD,
      S_TERM_DIV,
      S_TERM_MUL,
      S_ROOM,
      S_ACC,
      S_OUT
   } ctrl_state_type;

   // Command from controller to datapath.
   typedef struct packed {
      dp_op_type   op;
      div_src_type src;
   } dp_cmd_type;

   // Status from datapath to controller.
   typedef struct packed {
      logic n_last;
      logic m_zero;
      logic bad;
      logic r1_zero;
      logic gcd_bad;
   } dp_status_type;

   // Number of divider steps for each dividend source.
   function automatic logic [DIV_CNT_BITS-1:0] div_steps(input div_src_type src);
      logic [DIV_CNT_BITS-1:0] steps;
      case (src)
         DS_PROD, DS_COF: steps = DIV_CNT_BITS'(PROD_BITS);
         DS_MUL:          steps = DIV_CNT_BITS'(MUL_BITS);
         default:         steps = DIV_CNT_BITS'(IN_BITS);
      endcase
      return steps;
   endfunction

endpackage

>>> design/crcomb_dp.sv
// Datapath of the Chinese-remainder combiner: pair store, divider, Euclid and sum.
module crcomb_dp
   import crcomb_pkg::*;
#(
   parameter int MAX_PAIRS    = DEF_MAX_PAIRS,
   parameter int MODULUS_BITS = DEF_MODULUS_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [IN_BITS-1:0]     req_modulus,
   input  logic [IN_BITS-1:0]     req_residue,
   input  logic                   req_last_item,
   input  dp_cmd_type             cmd,
   input  logic [((MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1)-1:0] pair_idx,
   output dp_status_type          status,
   output logic                   rsp_valid,
   output logic [PROD_BITS-1:0]   rsp_combined_value,
   output logic                   rsp_not_coprime
);

   localparam int IW = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
   localparam int CW = $clog2(MAX_PAIRS + 1);
   localparam int MB = MODULUS_BITS;
   localparam int TW = MODULUS_BITS + 2;

   // Pair store and set bookkeeping.
   logic [MB-1:0]      mod_store_ff [MAX_PAIRS];
   logic [MB-1:0]      mod_store_in [MAX_PAIRS];
   logic [IN_BITS-1:0] res_store_ff [MAX_PAIRS];
   logic [IN_BITS-1:0] res_store_in [MAX_PAIRS];
   logic [CW-1:0]      pair_count_ff, pair_count_in;
   logic               bad_ff, bad_in;

   // Arithmetic registers.
   logic [PROD_BITS-1:0] prod_ff, prod_in;
   logic [PROD_BITS-1:0] sum_ff, sum_in;
   logic [PROD_BITS-1:0] cof_ff, cof_in;
   logic [PROD_BITS-1:0] term_ff, term_in;
   logic [PROD_BITS-1:0] room_ff, room_in;
   logic [PROD_BITS-1:0] div_ff, div_in;
   logic [MB-1:0]        rem_ff, rem_in;
   logic [MB-1:0]        dsor_ff, dsor_in;
   logic [MB-1:0]        r0_ff, r0_in;
   logic [MB-1:0]        r1_ff, r1_in;
   logic [MB-1:0]        rnew_ff, rnew_in;
   logic [MB-1:0]        inv_ff, inv_in;
   logic signed [TW-1:0] t0_ff, t0_in;
   logic signed [TW-1:0] t1_ff, t1_in;
   logic signed [TW-1:0] qt_ff, qt_in;
   logic [2*MB-1:0]      mul_ff, mul_in;

   // Response registers.
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [PROD_BITS-1:0] rsp_value_ff, rsp_value_in;
   logic                 rsp_nc_ff, rsp_nc_in;

   logic [MB-1:0]        m_sel;
   logic [IN_BITS-1:0]   r_sel;
   logic [MB:0]          div_shift;
   logic [MB:0]          div_trial;
   logic                 div_ge;
   logic [IW-1:0]        store_idx;

   assign m_sel     = mod_store_ff[pair_idx];
   assign r_sel     = res_store_ff[pair_idx];
   assign store_idx = pair_count_ff[IW-1:0];

   // One restoring division step: shift in the next dividend bit and try the divisor.
   assign div_shift = {rem_ff, div_ff[PROD_BITS-1]};
   assign div_trial = div_shift - {1'b0, dsor_ff};
   assign div_ge    = !div_trial[MB];

   // Status toward the controller.
   always_comb begin
      status.n_last  = (CW'(pair_idx) == (pair_count_ff - CW'(1)));
      status.m_zero  = (m_sel == '0);
      status.bad     = bad_ff;
      status.r1_zero = (r1_ff == '0);
      status.gcd_bad = (r0_ff != MB'(1));
   end

   // Next values for every register, chosen by the current command.
   always_comb begin
      mod_store_in  = mod_store_ff;
      res_store_in  = res_store_ff;
      pair_count_in = pair_count_ff;
      bad_in        = bad_ff;
      prod_in       = prod_ff;
      sum_in        = sum_ff;
      cof_in        = cof_ff;
      term_in       = term_ff;
      room_in       = room_ff;
      div_in        = div_ff;
      rem_in        = rem_ff;
      dsor_in       = dsor_ff;
      r0_in         = r0_ff;
      r1_in         = r1_ff;
      rnew_in       = rnew_ff;
      inv_in        = inv_ff;
      t0_in         = t0_ff;
      t1_in         = t1_ff;
      qt_in         = qt_ff;
      mul_in        = mul_ff;
      rsp_valid_in  = 1'b0;
      rsp_value_in  = rsp_value_ff;
      rsp_nc_in     = rsp_nc_ff;

      case (cmd.op)
         OP_LOAD: begin
            if (pair_count_ff < CW'(MAX_PAIRS)) begin
               mod_store_in[store_idx] = req_modulus[MB-1:0];
               res_store_in[store_idx] = req_residue;
               pair_count_in = pair_count_ff + CW'(1);
            end
            if (req_last_item) begin
               prod_in = PROD_BITS'(1);
               sum_in  = '0;
               bad_in  = 1'b0;
            end
         end
         OP_PROD: begin
            if (m_sel == '0) begin
               bad_in = 1'b1;
            end else begin
               prod_in = PROD_BITS'(prod_ff * PROD_BITS'(m_sel));
            end
         end
         OP_DIV_LOAD: begin
            rem_in  = '0;
            dsor_in = m_sel;
            case (cmd.src)
               DS_PROD: div_in = prod_ff;
               DS_COF: begin
                  cof_in = div_ff;
                  div_in = div_ff;
               end
               DS_R0: begin
                  div_in  = {IN_BITS'(r0_ff), {(PROD_BITS - IN_BITS){1'b0}}};
                  dsor_in = r1_ff;
               end
               DS_RES:  div_in = {r_sel, {(PROD_BITS - IN_BITS){1'b0}}};
               DS_MUL:  div_in = {MUL_BITS'(mul_ff), {(PROD_BITS - MUL_BITS){1'b0}}};
               default: div_in = prod_ff;
            endcase
         end
         OP_DIV_STEP: begin
            div_in = {div_ff[PROD_BITS-2:0], div_ge};
            rem_in = div_ge ? div_trial[MB-1:0] : div_shift[MB-1:0];
         end
         OP_EUC_INIT: begin
            r0_in = m_sel;
            r1_in = rem_ff;
            t0_in = '0;
            t1_in = TW'(1);
         end
         OP_EUC_MUL: begin
            qt_in   = TW'($signed({1'b0, div_ff[MB-1:0]}) * t1_ff);
            rnew_in = rem_ff;
         end
         OP_EUC_UPD: begin
            r0_in = r1_ff;
            r1_in = rnew_ff;
            t0_in = t1_ff;
            t1_in = t0_ff - qt_ff;
         end
         OP_INV: begin
            if (r0_ff != MB'(1)) begin
               bad_in = 1'b1;
            end
            if (t0_ff < 0) begin
               inv_in = MB'(t0_ff + $signed(TW'(m_sel)));
            end else begin
               inv_in = MB'(t0_ff);
            end
         end
         OP_RES_MUL:  mul_in  = rem_ff * inv_ff;
         OP_TERM_MUL: term_in = PROD_BITS'(cof_ff * PROD_BITS'(rem_ff));
         OP_ROOM:     room_in = prod_ff - sum_ff;
         OP_ACC: begin
            // Modular add without overflow: subtract the room left below the product.
            if (term_ff >= room_ff) begin
               sum_in = term_ff - room_ff;
            end else begin
               sum_in = sum_ff + term_ff;
            end
         end
         OP_OUT: begin
            rsp_valid_in  = 1'b1;
            rsp_value_in  = bad_ff ? '0 : sum_ff;
            rsp_nc_in     = bad_ff;
            pair_count_in = '0;
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         pair_count_ff <= '0;
         bad_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         pair_count_ff <= pair_count_in;
         bad_ff        <= bad_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      mod_store_ff <= mod_store_in;
      res_store_ff <= res_store_in;
      prod_ff      <= prod_in;
      sum_ff       <= sum_in;
      cof_ff       <= cof_in;
      term_ff      <= term_in;
      room_ff      <= room_in;
      div_ff       <= div_in;
      rem_ff       <= rem_in;
      dsor_ff      <= dsor_in;
      r0_ff        <= r0_in;
      r1_ff        <= r1_in;
      rnew_ff      <= rnew_in;
      inv_ff       <= inv_in;
      t0_ff        <= t0_in;
      t1_ff        <= t1_in;
      qt_ff        <= qt_in;
      mul_ff       <= mul_in;
      rsp_value_ff <= rsp_value_in;
      rsp_nc_ff    <= rsp_nc_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_combined_value = rsp_value_ff;
   assign rsp_not_coprime    = rsp_nc_ff;

   // The pair count never runs past the store depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      pair_count_ff <= CW'(MAX_PAIRS))
      else $error("pair count beyond store depth");

   // A response strobe lasts a single cycle.
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("response strobe held for two cycles");

   // A set without inverses reports a zero value.
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_nc_ff) |-> (rsp_value_ff == '0))
      else $error("nonzero value with not_coprime set");

endmodule

>>> design/crcomb_ctrl.sv
// Controller state machine of the Chinese-remainder combiner.
module crcomb_ctrl
   import crcomb_pkg::*;
#(
   parameter int MAX_PAIRS = DEF_MAX_PAIRS
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic          req_last_item,
   input  dp_status_type status,
   output dp_cmd_type    cmd,
   output logic [((MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1)-1:0] pair_idx,
   output logic          busy
);

   localparam int IW = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;

   ctrl_state_type          state_ff, state_in;
   logic [IW-1:0]           idx_ff, idx_in;
   logic [DIV_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                    cnt_end;

   assign cnt_end = (cnt_ff == DIV_CNT_BITS'(1));

   // Next state and pair index.
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      case (state_ff)
         S_IDLE: begin
            if (start && req_last_item) begin
               state_in = S_PROD;
               idx_in   = '0;
            end
         end
         S_PROD: begin
            if (status.n_last) begin
               idx_in   = '0;
               state_in = (status.bad || status.m_zero) ? S_OUT : S_COF_LD;
            end else begin
               idx_in = idx_ff + IW'(1);
            end
         end
         S_COF_LD:   state_in = S_COF_DIV;
         S_COF_DIV:  if (cnt_end) state_in = S_X_LD;
         S_X_LD:     state_in = S_X_DIV;
         S_X_DIV:    if (cnt_end) state_in = S_EUC_INIT;
         S_EUC_INIT: state_in = S_EUC_TEST;
         S_EUC_TEST: state_in = status.r1_zero ? S_INV : S_EUC_DIV;
         S_EUC_DIV:  if (cnt_end) state_in = S_EUC_MUL;
         S_EUC_MUL:  state_in = S_EUC_UPD;
         S_EUC_UPD:  state_in = S_EUC_TEST;
         S_INV:      state_in = status.gcd_bad ? S_OUT : S_RES_LD;
         S_RES_LD:   state_in = S_RES_DIV;
         S_RES_DIV:  if (cnt_end) state_in = S_RES_MUL;
         S_RES_MUL:  state_in = S_TERM_LD;
         S_TERM_LD:  state_in = S_TERM_DIV;
         S_TERM_DIV: if (cnt_end) state_in = S_TERM_MUL;
         S_TERM_MUL: state_in = S_ROOM;
         S_ROOM:     state_in = S_ACC;
         S_ACC: begin
            if (status.n_last) begin
               state_in = S_OUT;
            end else begin
               idx_in   = idx_ff + IW'(1);
               state_in = S_COF_LD;
            end
         end
         S_OUT:   state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // Datapath command for each state.
   always_comb begin
      cmd.op  = OP_NONE;
      cmd.src = DS_PROD;
      case (state_ff)
         S_IDLE:     cmd.op = start ? OP_LOAD : OP_NONE;
         S_PROD:     cmd.op = OP_PROD;
         S_COF_LD: begin
            cmd.op  = OP_DIV_LOAD;
            cmd.src = DS_PROD;
         end
         S_X_LD: begin
            cmd.op  = OP_DIV_LOAD;
            cmd.src = DS_COF;
         end
         S_EUC_TEST: begin
            cmd.op  = status.r1_zero ? OP_NONE : OP_DIV_LOAD;
            cmd.src = DS_R0;
         end
         S_RES_LD: begin
            cmd.op  = OP_DIV_LOAD;
            cmd.src = DS_RES;
         end
         S_TERM_LD: begin
            cmd.op  = OP_DIV_LOAD;
            cmd.src = DS_MUL;
         end
         S_COF_DIV, S_X_DIV, S_EUC_DIV, S_RES_DIV, S_TERM_DIV: cmd.op = OP_DIV_STEP;
         S_EUC_INIT: cmd.op = OP_EUC_INIT;
         S_EUC_MUL:  cmd.op = OP_EUC_MUL;
         S_EUC_UPD:  cmd.op = OP_EUC_UPD;
         S_INV:      cmd.op = OP_INV;
         S_RES_MUL:  cmd.op = OP_RES_MUL;
         S_TERM_MUL: cmd.op = OP_TERM_MUL;
         S_ROOM:     cmd.op = OP_ROOM;
         S_ACC:      cmd.op = OP_ACC;
         S_OUT:      cmd.op = OP_OUT;
         default:    cmd.op = OP_NONE;
      endcase
   end

   // Divider step counter, loaded with each division.
   always_comb begin
      cnt_in = cnt_ff;
      if (cmd.op == OP_DIV_LOAD) begin
         cnt_in = div_steps(cmd.src);
      end else if (cmd.op == OP_DIV_STEP) begin
         cnt_in = cnt_ff - DIV_CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         idx_ff   <= '0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         cnt_ff   <= cnt_in;
      end
   end

   assign pair_idx = idx_ff;
   assign busy     = (state_ff != S_IDLE);

endmodule

>>> design/chinese_remainder_combine.sv
// Top level of the Chinese-remainder combiner.
//
// Requests: one (modulus, residue) pair per request, taken at a rising edge
// with start high and busy low. Pairs that are not last leave busy low,
// so a set loads back to back. Up to MAX_PAIRS pairs are kept; extra pairs
// are dropped.
// The request marked last raises busy while the set is solved. The product
// is formed pair by pair. Each pair then takes two 64-step divisions, an
// extended Euclid loop of rounds that each hold a 16-step division plus
// load, multiply and update, a 16-step and a 32-step division, a multiply
// and a modular add. All divisions share the single shift-subtract divider.
// The response is registered from the output state and shows on rsp_valid
// for one cycle; busy falls at the same time, so the next set may begin
// at once.
// The receiver cannot stall; it must take the response in that cycle.
// Reset clears the pair count, the state machine and the strobe; stored
// pairs are not cleared and are overwritten by the next set.
module chinese_remainder_combine
   import crcomb_pkg::*;
#(
   parameter int MAX_PAIRS    = DEF_MAX_PAIRS,
   parameter int MODULUS_BITS = DEF_MODULUS_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [IN_BITS-1:0]   req_modulus,
   input  logic [IN_BITS-1:0]   req_residue,
   input  logic                 req_last_item,
   output logic                 rsp_valid,
   output logic [PROD_BITS-1:0] rsp_combined_value,
   output logic                 rsp_not_coprime
);

   localparam int IW = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;

   dp_cmd_type    cmd;
   dp_status_type status;
   logic [IW-1:0] pair_idx;
   logic          ctrl_start;

   // A request is only passed on while the block is idle.
   assign ctrl_start = start && !busy;

   crcomb_ctrl #(
      .MAX_PAIRS(MAX_PAIRS)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .start        (ctrl_start),
      .req_last_item(req_last_item),
      .status       (status),
      .cmd          (cmd),
      .pair_idx     (pair_idx),
      .busy         (busy)
   );

   crcomb_dp #(
      .MAX_PAIRS   (MAX_PAIRS),
      .MODULUS_BITS(MODULUS_BITS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .req_modulus       (req_modulus),
      .req_residue       (req_residue),
      .req_last_item     (req_last_item),
      .cmd               (cmd),
      .pair_idx          (pair_idx),
      .status            (status),
      .rsp_valid         (rsp_valid),
      .rsp_combined_value(rsp_combined_value),
      .rsp_not_coprime   (rsp_not_coprime)
   );

endmodule
